// File: rtl/bpa_pkg.sv
// Buddy page allocator: shared constants, codes and controller/datapath types.
// No dependencies.
package bpa_pkg;

  localparam int unsigned NUM_PAGES  = 65536;
  localparam int unsigned NUM_ORDERS = 11;
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned ORDER_W    = 4;
  localparam int unsigned LINK_W     = PAGE_W + 1;
  localparam int unsigned META_W     = ORDER_W + 1;
  localparam int unsigned ORD_IDX_W  = $clog2(NUM_ORDERS);

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_FREE     = 2'd1,
    REQ_FREE_BLK = 2'd2
  } bpa_req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_BLOCK = 2'd1,
    STAT_REJECT   = 2'd2
  } bpa_status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_SCAN, S_UL_RD, S_UL_WR, S_SPLIT,
    S_PUSH1, S_PUSH2, S_A_FIN, S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_DONE
  } bpa_state_e;

  typedef enum logic [3:0] {
    CMD_CLEAR, CMD_LOAD, CMD_NONE, CMD_SCAN, CMD_UL_RD, CMD_UL_WR, CMD_SPLIT,
    CMD_PUSH1, CMD_PUSH2, CMD_A_FIN, CMD_F_RD, CMD_F_CHK, CMD_M_RD, CMD_M_CHK,
    CMD_OUT
  } bpa_cmd_e;

  typedef struct packed {
    logic clr_done;
    logic is_alloc;
    logic is_free;
    logic ord_bad;
    logic head_hit;
    logic scan_end;
    logic split_more;
    logic free_ok;
    logic merge_top;
    logic merge_ok;
    logic out_free;
  } bpa_stat_t;

endpackage

// File: rtl/bpa_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on bpa_pkg.
interface bpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [bpa_pkg::PAGE_W-1:0]   page_num;
  logic [bpa_pkg::ORDER_W-1:0]  block_order;

  modport source (output valid, req_type, page_num, block_order, input ready);
  modport sink   (input valid, req_type, page_num, block_order, output ready);
endinterface

// File: rtl/bpa_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on bpa_pkg.
interface bpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bpa_pkg::PAGE_W-1:0]   result_page;
  logic [bpa_pkg::ORDER_W-1:0]  result_order;

  modport source (output valid, status, result_page, result_order, input ready);
  modport sink   (input valid, status, result_page, result_order, output ready);
endinterface

// File: rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/bpa_ctrl.sv
// Allocator sequencer: walks scan, unlink, split, push and merge steps.
// Depends on bpa_pkg.
module bpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bpa_pkg::bpa_stat_t stat_i,
  output logic               in_ready_o,
  output bpa_pkg::bpa_cmd_e  cmd_o
);
  bpa_pkg::bpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::S_CLEAR:    if (stat_i.clr_done) state_d = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE:     if (in_valid_i) state_d = bpa_pkg::S_DISPATCH;
      bpa_pkg::S_DISPATCH: begin
        if (stat_i.is_alloc && !stat_i.ord_bad) state_d = bpa_pkg::S_A_SCAN;
        else if (stat_i.is_free)                state_d = bpa_pkg::S_F_RD;
        else                                    state_d = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_A_SCAN: begin
        if (stat_i.head_hit)      state_d = bpa_pkg::S_UL_RD;
        else if (stat_i.scan_end) state_d = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_UL_RD:    state_d = bpa_pkg::S_UL_WR;
      bpa_pkg::S_UL_WR:    state_d = stat_i.is_alloc ? bpa_pkg::S_SPLIT : bpa_pkg::S_M_RD;
      bpa_pkg::S_SPLIT:    state_d = stat_i.split_more ? bpa_pkg::S_PUSH1 : bpa_pkg::S_A_FIN;
      bpa_pkg::S_PUSH1:    state_d = bpa_pkg::S_PUSH2;
      bpa_pkg::S_PUSH2:    state_d = stat_i.is_alloc ? bpa_pkg::S_SPLIT : bpa_pkg::S_DONE;
      bpa_pkg::S_A_FIN:    state_d = bpa_pkg::S_DONE;
      bpa_pkg::S_F_RD:     state_d = bpa_pkg::S_F_CHK;
      bpa_pkg::S_F_CHK:    state_d = stat_i.free_ok ? bpa_pkg::S_M_RD : bpa_pkg::S_DONE;
      bpa_pkg::S_M_RD:     state_d = stat_i.merge_top ? bpa_pkg::S_PUSH1 : bpa_pkg::S_M_CHK;
      bpa_pkg::S_M_CHK:    state_d = stat_i.merge_ok ? bpa_pkg::S_UL_RD : bpa_pkg::S_PUSH1;
      bpa_pkg::S_DONE:     if (stat_i.out_free) state_d = bpa_pkg::S_IDLE;
      default:             state_d = bpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = bpa_pkg::CMD_NONE;
    unique case (state_q)
      bpa_pkg::S_CLEAR:    cmd_o = bpa_pkg::CMD_CLEAR;
      bpa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o      = bpa_pkg::CMD_LOAD;
      end
      bpa_pkg::S_DISPATCH: cmd_o = bpa_pkg::CMD_NONE;
      bpa_pkg::S_A_SCAN:   cmd_o = bpa_pkg::CMD_SCAN;
      bpa_pkg::S_UL_RD:    cmd_o = bpa_pkg::CMD_UL_RD;
      bpa_pkg::S_UL_WR:    cmd_o = bpa_pkg::CMD_UL_WR;
      bpa_pkg::S_SPLIT:    cmd_o = bpa_pkg::CMD_SPLIT;
      bpa_pkg::S_PUSH1:    cmd_o = bpa_pkg::CMD_PUSH1;
      bpa_pkg::S_PUSH2:    cmd_o = bpa_pkg::CMD_PUSH2;
      bpa_pkg::S_A_FIN:    cmd_o = bpa_pkg::CMD_A_FIN;
      bpa_pkg::S_F_RD:     cmd_o = bpa_pkg::CMD_F_RD;
      bpa_pkg::S_F_CHK:    cmd_o = bpa_pkg::CMD_F_CHK;
      bpa_pkg::S_M_RD:     cmd_o = bpa_pkg::CMD_M_RD;
      bpa_pkg::S_M_CHK:    cmd_o = bpa_pkg::CMD_M_CHK;
      bpa_pkg::S_DONE:     cmd_o = bpa_pkg::CMD_OUT;
      default:             cmd_o = bpa_pkg::CMD_NONE;
    endcase
  end
endmodule

// File: rtl/bpa_dp.sv
// Allocator datapath: list heads, link and page-metadata RAMs, result register.
// Depends on bpa_pkg, bpa_ram, bpa_req_if, bpa_rsp_if.
module bpa_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpa_pkg::bpa_cmd_e  cmd_i,
  input  logic               in_ready_i,
  bpa_req_if.sink            req_i,
  bpa_rsp_if.source          rsp_o,
  output bpa_pkg::bpa_stat_t stat_o
);
  localparam int unsigned PW = bpa_pkg::PAGE_W;
  localparam int unsigned OW = bpa_pkg::ORDER_W;
  localparam int unsigned LW = bpa_pkg::LINK_W;
  localparam int unsigned MW = bpa_pkg::META_W;
  localparam int unsigned IW = bpa_pkg::ORD_IDX_W;
  localparam logic [OW-1:0] TOP_ORD = OW'(bpa_pkg::NUM_ORDERS - 1);

  logic [LW-1:0] head_q [bpa_pkg::NUM_ORDERS];
  logic [1:0]    req_q;
  logic [PW-1:0] pg_q;
  logic [OW-1:0] ord_q, cur_q;
  logic [1:0]    res_stat_q;
  logic [PW-1:0] res_page_q;
  logic [OW-1:0] res_ord_q;
  logic          out_valid_q;
  logic [1:0]    out_stat_q;
  logic [PW-1:0] out_page_q;
  logic [OW-1:0] out_ord_q;
  logic [PW-1:0] clr_cnt_q;

  logic          is_alloc;
  logic [PW-1:0] buddy, ul_pg, push_pg;
  logic [OW-1:0] ul_ord, push_ord, eff_ord;
  logic [LW-1:0] cur_head, push_head;

  logic          nx_we, pv_we, mt_we;
  logic [PW-1:0] nx_wa, pv_wa, mt_wa, mt_ra;
  logic [LW-1:0] nx_wd, nx_rd;
  logic [LW-1:0] pv_wd, pv_rd;
  logic [MW-1:0] mt_wd, mt_rd;

  assign is_alloc  = (req_q == bpa_pkg::REQ_ALLOC);
  assign buddy     = pg_q ^ (PW'(1) << ord_q);
  assign ul_pg     = is_alloc ? pg_q : buddy;
  assign ul_ord    = is_alloc ? cur_q : ord_q;
  assign push_pg   = is_alloc ? (pg_q + (PW'(1) << cur_q)) : pg_q;
  assign push_ord  = is_alloc ? cur_q : ord_q;
  assign cur_head  = head_q[IW'(cur_q)];
  assign push_head = head_q[IW'(push_ord)];
  assign eff_ord   = (req_q == bpa_pkg::REQ_FREE) ? mt_rd[OW-1:0] : ord_q;

  // both link RAMs carry an end-of-list flag in the top bit
  bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_PAGES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(ul_pg), .rdata_o(nx_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_PAGES)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(ul_pg), .rdata_o(pv_rd)
  );
  bpa_ram #(.WIDTH(MW), .DEPTH(bpa_pkg::NUM_PAGES)) u_meta (
    .clk_i, .we_i(mt_we), .waddr_i(mt_wa), .wdata_i(mt_wd), .raddr_i(mt_ra), .rdata_o(mt_rd)
  );

  always_comb begin
    nx_we = 1'b0; nx_wa = push_pg; nx_wd = push_head;
    pv_we = 1'b0; pv_wa = push_pg; pv_wd = {1'b1, PW'(0)};
    mt_we = 1'b0; mt_wa = push_pg; mt_wd = {1'b1, push_ord};
    mt_ra = (cmd_i == bpa_pkg::CMD_M_RD) ? buddy : pg_q;
    case (cmd_i)
      bpa_pkg::CMD_CLEAR: begin
        mt_we = 1'b1; mt_wa = clr_cnt_q; mt_wd = '0;
      end
      bpa_pkg::CMD_UL_WR: begin
        nx_we = !pv_rd[LW-1]; nx_wa = pv_rd[PW-1:0]; nx_wd = nx_rd;
        pv_we = !nx_rd[LW-1]; pv_wa = nx_rd[PW-1:0]; pv_wd = pv_rd;
        mt_we = 1'b1;         mt_wa = ul_pg;         mt_wd = '0;
      end
      bpa_pkg::CMD_PUSH1: begin
        nx_we = 1'b1; pv_we = 1'b1; mt_we = 1'b1;
      end
      bpa_pkg::CMD_PUSH2: begin
        pv_we = !push_head[LW-1]; pv_wa = push_head[PW-1:0]; pv_wd = {1'b0, push_pg};
      end
      bpa_pkg::CMD_A_FIN: begin
        mt_we = 1'b1; mt_wa = pg_q; mt_wd = {1'b0, ord_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(bpa_pkg::NUM_ORDERS); i++) head_q[i] <= {1'b1, PW'(0)};
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i == bpa_pkg::CMD_OUT && stat_o.out_free) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      case (cmd_i)
        bpa_pkg::CMD_CLEAR: clr_cnt_q <= clr_cnt_q + PW'(1);
        bpa_pkg::CMD_UL_WR: begin
          if (pv_rd[LW-1]) head_q[IW'(ul_ord)] <= nx_rd;
        end
        bpa_pkg::CMD_PUSH2: head_q[IW'(push_ord)] <= {1'b0, push_pg};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bpa_pkg::CMD_LOAD: begin
        if (req_i.valid) begin
          req_q      <= req_i.req_type;
          pg_q       <= req_i.page_num;
          ord_q      <= req_i.block_order;
          cur_q      <= req_i.block_order;
          res_stat_q <= bpa_pkg::STAT_REJECT;
          res_page_q <= '0;
          res_ord_q  <= '0;
        end
      end
      bpa_pkg::CMD_SCAN: begin
        if (!cur_head[LW-1]) begin
          pg_q <= cur_head[PW-1:0];
        end else if (cur_q == TOP_ORD) begin
          res_stat_q <= bpa_pkg::STAT_NO_BLOCK;
        end else begin
          cur_q <= cur_q + OW'(1);
        end
      end
      bpa_pkg::CMD_UL_WR: begin
        if (!is_alloc) begin
          pg_q  <= pg_q & ~(PW'(1) << ord_q);
          ord_q <= ord_q + OW'(1);
        end
      end
      bpa_pkg::CMD_SPLIT: begin
        if (cur_q > ord_q) cur_q <= cur_q - OW'(1);
      end
      bpa_pkg::CMD_PUSH2: begin
        if (!is_alloc) begin
          res_stat_q <= bpa_pkg::STAT_OK;
          res_page_q <= pg_q;
          res_ord_q  <= ord_q;
        end
      end
      bpa_pkg::CMD_A_FIN: begin
        res_stat_q <= bpa_pkg::STAT_OK;
        res_page_q <= pg_q;
        res_ord_q  <= ord_q;
      end
      bpa_pkg::CMD_F_CHK: ord_q <= eff_ord;
      bpa_pkg::CMD_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_stat_q <= res_stat_q;
          out_page_q <= res_page_q;
          out_ord_q  <= res_ord_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clr_done   = (clr_cnt_q == '1);
    stat_o.is_alloc   = is_alloc;
    stat_o.is_free    = (req_q == bpa_pkg::REQ_FREE) || (req_q == bpa_pkg::REQ_FREE_BLK);
    stat_o.ord_bad    = (ord_q > TOP_ORD);
    stat_o.head_hit   = !cur_head[LW-1];
    stat_o.scan_end   = (cur_q == TOP_ORD);
    stat_o.split_more = (cur_q > ord_q);
    stat_o.free_ok    = (eff_ord <= TOP_ORD) && !mt_rd[MW-1] &&
                        ((pg_q & ((PW'(1) << eff_ord) - PW'(1))) == '0);
    stat_o.merge_top  = (ord_q >= TOP_ORD);
    stat_o.merge_ok   = mt_rd[MW-1] && (mt_rd[OW-1:0] == ord_q);
    stat_o.out_free   = !out_valid_q || rsp_o.ready;
  end

  assign req_i.ready        = in_ready_i;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_stat_q;
  assign rsp_o.result_page  = out_page_q;
  assign rsp_o.result_order = out_ord_q;
endmodule

// File: rtl/buddy_page_allocator_top.sv
// Buddy page allocator top level: sequencer plus datapath.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl, bpa_dp.
//
// One request is worked at a time. After reset the page-metadata RAM is
// cleared one entry a cycle with req_i.ready low. A request then passes
// through accept, dispatch and result; allocate adds an order scan, an
// unlink, a split and push per split level and a finish step; free adds a
// metadata check, a buddy check and unlink per merge level and a final
// push (the merge stops at the top order). Requests rejected at dispatch
// go straight to the result state. The result word is held in an output
// register until taken; a new request is accepted once the result has
// been loaded into it.
module buddy_page_allocator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);
  bpa_pkg::bpa_cmd_e  cmd;
  bpa_pkg::bpa_stat_t stat;
  logic               in_ready;

  bpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(req_i.valid), .stat_i(stat),
    .in_ready_o(in_ready), .cmd_o(cmd)
  );

  bpa_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_ready_i(in_ready), .req_i, .rsp_o, .stat_o(stat)
  );
endmodule
